/* sv/qrs_pkg.sv */
// ============================================================================
// qrs_pkg: shared definitions for the quadratic root solver
// Default sizes, root width and solution kind codes.
// ============================================================================
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ROOT_WIDTH     = 35;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_NONE = 2'd0;
    localparam t_kind KIND_ONE  = 2'd1;
    localparam t_kind KIND_TWO  = 2'd2;
    localparam t_kind KIND_ALL  = 2'd3;

endpackage

/* sv/qrs_if.sv */
// ============================================================================
// qrs_if: item channels of the quadratic root solver
// Coefficient channel and root channel, valid/ready handshake.
// ============================================================================
interface qrs_in_if #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
    logic                                  valid;
    logic                                  ready;
    qrs_pkg::t_kind                        solution_kind;
    logic signed [qrs_pkg::ROOT_WIDTH-1:0] first_root;
    logic signed [qrs_pkg::ROOT_WIDTH-1:0] second_root;

    modport source (output valid, solution_kind, first_root, second_root, input ready);
    modport sink   (input valid, solution_kind, first_root, second_root, output ready);
endinterface

/* sv/qrs_sqrt_cell.sv */
// ============================================================================
// qrs_sqrt_cell: one digit of the square root chain
// Takes two radicand bits, decides one root bit, hands on to the next cell.
// ============================================================================
module qrs_sqrt_cell #(
    parameter int SW = 17,
    parameter int TW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SW+1:0]     i_rem,
    input  logic [SW-1:0]     i_root,
    input  logic [2*SW-1:0]   i_rad,
    input  logic [TW-1:0]     i_tag,
    output logic              o_valid,
    output logic [SW+1:0]     o_rem,
    output logic [SW-1:0]     o_root,
    output logic [2*SW-1:0]   o_rad,
    output logic [TW-1:0]     o_tag
);

    logic [SW+1:0]   rem_sh;
    logic [SW+1:0]   trial;
    logic            take;
    logic [SW+1:0]   n_rem;
    logic [SW-1:0]   n_root;
    logic [2*SW-1:0] n_rad;

    logic            r_valid;
    logic [SW+1:0]   r_rem;
    logic [SW-1:0]   r_root;
    logic [2*SW-1:0] r_rad;
    logic [TW-1:0]   r_tag;

    always_comb begin
        rem_sh = {i_rem[SW-1:0], i_rad[2*SW-1 -: 2]};
        trial  = {i_root, 2'b01};
        take   = (rem_sh >= trial);
        n_rem  = take ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[SW-2:0], take};
        n_rad  = {i_rad[2*SW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_tag  <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_tag   = r_tag;

endmodule

/* sv/qrs_div_cell.sv */
// ============================================================================
// qrs_div_cell: one quotient bit of the dual restoring divider chain
// Both lanes share the divisor; quotient bits shift in as numerator bits leave.
// ============================================================================
module qrs_div_cell #(
    parameter int NW  = 33,
    parameter int DNW = 17,
    parameter int TW  = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [1:0][NW-1:0]     i_num,
    input  logic [1:0][DNW-1:0]    i_rem,
    input  logic [DNW-1:0]         i_den,
    input  logic [TW-1:0]          i_tag,
    output logic                   o_valid,
    output logic [1:0][NW-1:0]     o_num,
    output logic [1:0][DNW-1:0]    o_rem,
    output logic [DNW-1:0]         o_den,
    output logic [TW-1:0]          o_tag
);

    logic [1:0][DNW:0]   rs;
    logic [1:0][DNW:0]   diff;
    logic [1:0]          take;
    logic [1:0][NW-1:0]  n_num;
    logic [1:0][DNW-1:0] n_rem;

    logic                r_valid;
    logic [1:0][NW-1:0]  r_num;
    logic [1:0][DNW-1:0] r_rem;
    logic [DNW-1:0]      r_den;
    logic [TW-1:0]       r_tag;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            rs[k]    = {i_rem[k], i_num[k][NW-1]};
            diff[k]  = rs[k] - {1'b0, i_den};
            take[k]  = (rs[k] >= {1'b0, i_den});
            n_rem[k] = take[k] ? diff[k][DNW-1:0] : rs[k][DNW-1:0];
            n_num[k] = {i_num[k][NW-2:0], take[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_den <= i_den;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_tag   = r_tag;

endmodule

/* sv/quadratic_root_solver_top.sv */
// ============================================================================
// quadratic_root_solver_top: real roots of a*x^2 + b*x + c = 0
// Pipelined classifier, square root chain and dual divider chain.
// ============================================================================
// Usage:
//   i_coef carries one coefficient triple per item (valid/ready); o_root
//   carries one result item per input item: the solution kind and up to two
//   roots in signed fixed point with FRAC_BITS fraction bits, truncated toward
//   zero and saturated to 35 bits. Unused root fields read zero.
//   Throughput: one item per cycle unless the result side stalls (see Stall).
//   The pipeline depth is set by the square root chain (one cell per root bit)
//   and the divider chain (one cell per quotient bit).
//   Stall: the result side has an output register plus one skid entry. While
//   o_root.ready is low the pipeline keeps running until the skid entry
//   fills; then the whole chain holds and i_coef.ready drops. No item is lost.
//   Reset (synchronous, i_rst_n low) empties the pipeline; no clearing pass.
// ============================================================================
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrs_in_if.sink     i_coef,
    qrs_out_if.source  o_root
);

    localparam int CW  = COEF_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int RW  = qrs_pkg::ROOT_WIDTH;
    localparam int DW  = 2*CW + 1;            // discriminant magnitude
    localparam int NW  = CW + FB + 1;         // root of scaled D, numerator magnitude
    localparam int SW  = NW;
    localparam int VW  = 2*SW;
    localparam int DNW = CW + 1;              // divisor magnitude
    localparam int TWS = 2 + NW + DNW;        // kind, numerator, divisor
    localparam int TWD = 4;                   // kind, two quotient signs
    localparam int QX  = ((NW > RW) ? NW : RW) + 1;
    localparam logic signed [QX-1:0] RMAX = QX'((64'd1 << (RW-1)) - 64'd1);
    localparam logic signed [QX-1:0] RMIN = -RMAX - QX'(1);

    logic en;

    // ---------------- input register ----------------
    logic                 r0_v;
    logic signed [CW-1:0] r0_a, r0_b, r0_c;

    // ---------------- product stage ----------------
    logic                   r1_v;
    logic signed [CW-1:0]   r1_a, r1_b, r1_c;
    logic signed [2*CW-1:0] r1_bb, r1_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_coef.valid;
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_a  <= i_coef.coef_a;
            r0_b  <= i_coef.coef_b;
            r0_c  <= i_coef.coef_c;
            r1_a  <= r0_a;
            r1_b  <= r0_b;
            r1_c  <= r0_c;
            r1_bb <= r0_b * r0_b;
            r1_ac <= r0_a * r0_c;
        end
    end

    // ---------------- classify ----------------
    logic signed [2*CW+2:0] d_full;
    qrs_pkg::t_kind         kind0;
    logic [DW-1:0]          dmag;
    logic signed [NW-1:0]   nb0;
    logic signed [CW:0]     den0;
    logic [VW-1:0]          rad0;

    always_comb begin
        d_full = (2*CW+3)'(r1_bb) - ((2*CW+3)'(r1_ac) <<< 2);
        dmag   = '0;
        nb0    = -(NW'(r1_b)) <<< FB;
        den0   = (CW+1)'(r1_a) <<< 1;
        if (r1_a == '0) begin
            nb0  = -(NW'(r1_c)) <<< FB;
            den0 = (CW+1)'(r1_b);
            if (r1_b != '0) begin
                kind0 = qrs_pkg::KIND_ONE;
            end else if (r1_c == '0) begin
                kind0 = qrs_pkg::KIND_ALL;
            end else begin
                kind0 = qrs_pkg::KIND_NONE;
            end
        end else if (d_full[2*CW+2]) begin
            kind0 = qrs_pkg::KIND_NONE;
        end else if (d_full == '0) begin
            kind0 = qrs_pkg::KIND_ONE;
        end else begin
            kind0 = qrs_pkg::KIND_TWO;
            dmag  = d_full[DW-1:0];
        end
        rad0 = VW'(dmag) << (2*FB);
    end

    // ---------------- square root chain ----------------
    logic             sq_v    [SW+1];
    logic [SW+1:0]    sq_rem  [SW+1];
    logic [SW-1:0]    sq_root [SW+1];
    logic [VW-1:0]    sq_rad  [SW+1];
    logic [TWS-1:0]   sq_tag  [SW+1];

    assign sq_v[0]    = r1_v;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = rad0;
    assign sq_tag[0]  = {kind0, nb0, den0};

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        qrs_sqrt_cell #(.SW(SW), .TW(TWS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_rad   (sq_rad[g]),
            .i_tag   (sq_tag[g]),
            .o_valid (sq_v[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_tag   (sq_tag[g+1])
        );
    end

    // ---------------- numerator stage ----------------
    qrs_pkg::t_kind       kind1;
    logic signed [NW-1:0] nb1;
    logic signed [CW:0]   den1;
    logic signed [NW:0]   n1, n2;
    logic [1:0][NW-1:0]   nmag;
    logic [DNW-1:0]       dnm;

    always_comb begin
        {kind1, nb1, den1} = sq_tag[SW];
        n1      = (NW+1)'(nb1) - signed'({1'b0, sq_root[SW]});
        n2      = (NW+1)'(nb1) + signed'({1'b0, sq_root[SW]});
        nmag[0] = n1[NW] ? NW'(-n1) : NW'(n1);
        nmag[1] = n2[NW] ? NW'(-n2) : NW'(n2);
        dnm     = den1[CW] ? DNW'(-den1) : DNW'(den1);
    end

    logic               r3_v;
    logic [1:0][NW-1:0] r3_num;
    logic [DNW-1:0]     r3_den;
    logic [TWD-1:0]     r3_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= sq_v[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num <= nmag;
            r3_den <= dnm;
            r3_tag <= {kind1, n1[NW] ^ den1[CW], n2[NW] ^ den1[CW]};
        end
    end

    // ---------------- divider chain ----------------
    logic                dv_v   [NW+1];
    logic [1:0][NW-1:0]  dv_num [NW+1];
    logic [1:0][DNW-1:0] dv_rem [NW+1];
    logic [DNW-1:0]      dv_den [NW+1];
    logic [TWD-1:0]      dv_tag [NW+1];

    assign dv_v[0]   = r3_v;
    assign dv_num[0] = r3_num;
    assign dv_rem[0] = '0;
    assign dv_den[0] = r3_den;
    assign dv_tag[0] = r3_tag;

    for (genvar g = 0; g < NW; g++) begin : g_div
        qrs_div_cell #(.NW(NW), .DNW(DNW), .TW(TWD)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_num   (dv_num[g]),
            .i_rem   (dv_rem[g]),
            .i_den   (dv_den[g]),
            .i_tag   (dv_tag[g]),
            .o_valid (dv_v[g+1]),
            .o_num   (dv_num[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_den   (dv_den[g+1]),
            .o_tag   (dv_tag[g+1])
        );
    end

    // ---------------- sign, saturate, select ----------------
    qrs_pkg::t_kind        kind2;
    logic [1:0]            qsgn;
    logic signed [QX-1:0]  qv [2];
    logic [1:0][RW-1:0]    qr;
    logic [RW-1:0]         root1, root2;

    always_comb begin
        {kind2, qsgn} = dv_tag[NW];
        for (int k = 0; k < 2; k++) begin
            qv[k] = signed'(QX'(dv_num[NW][k]));
            if (qsgn[1-k]) begin
                qv[k] = -qv[k];
            end
            if (qv[k] > RMAX) begin
                qr[k] = RMAX[RW-1:0];
            end else if (qv[k] < RMIN) begin
                qr[k] = RMIN[RW-1:0];
            end else begin
                qr[k] = qv[k][RW-1:0];
            end
        end
        case (kind2)
            qrs_pkg::KIND_TWO: begin
                root1 = qr[0];
                root2 = qr[1];
            end
            qrs_pkg::KIND_ONE: begin
                root1 = qr[0];
                root2 = '0;
            end
            default: begin
                root1 = '0;
                root2 = '0;
            end
        endcase
    end

    // ---------------- output register and skid entry ----------------
    logic           push, pop;
    logic           r_hv, r_sv;
    qrs_pkg::t_kind r_h_kind, r_s_kind;
    logic [RW-1:0]  r_h_r1, r_h_r2, r_s_r1, r_s_r2;

    assign en   = !r_sv;
    assign push = en && dv_v[NW];
    assign pop  = r_hv && o_root.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_sv <= 1'b0;
        end else if (pop) begin
            if (r_sv) begin
                r_sv <= 1'b0;
            end else begin
                r_hv <= push;
            end
        end else if (push) begin
            if (r_hv) begin
                r_sv <= 1'b1;
            end else begin
                r_hv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_sv) begin
            r_h_kind <= r_s_kind;
            r_h_r1   <= r_s_r1;
            r_h_r2   <= r_s_r2;
        end else if (push && (pop || !r_hv)) begin
            r_h_kind <= kind2;
            r_h_r1   <= root1;
            r_h_r2   <= root2;
        end
        if (push && r_hv && !pop) begin
            r_s_kind <= kind2;
            r_s_r1   <= root1;
            r_s_r2   <= root2;
        end
    end

    assign i_coef.ready         = en;
    assign o_root.valid         = r_hv;
    assign o_root.solution_kind = r_h_kind;
    assign o_root.first_root    = r_h_r1;
    assign o_root.second_root   = r_h_r2;

endmodule

/* test/quadratic_root_solver_top_tb.sv */
// ============================================================================
// quadratic_root_solver_top_tb: self-checking bench for the root solver
// Drives coefficient triples with random gaps, checks every result item
// against an exact integer predictor of kind and both Q18.16 roots.
// ============================================================================
module quadratic_root_solver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = qrs_pkg::COEF_WIDTH_DEF;
    localparam int FB = qrs_pkg::FRAC_BITS_DEF;
    localparam int RW = qrs_pkg::ROOT_WIDTH;
    localparam int N_RANDOM = 1300;
    localparam int LATENCY = 2 * (CW + FB + 1) + 3;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct {
        qrs_pkg::t_kind       kind;
        logic signed [RW-1:0] r1;
        logic signed [RW-1:0] r2;
    } t_roots;

    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        bit                   typed;
        t_roots               want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycle = 0;
    int errors = 0;
    bit tail_phase = 0;
    t_roots roots_q[$];

    qrs_in_if  #(.COEF_WIDTH(CW)) coef_ch();
    qrs_out_if                    root_ch();

    quadratic_root_solver_top #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_coef (coef_ch.sink),
        .o_root (root_ch.source)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Integer square root, floor.
    function automatic longint isqrt(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] sq;
        r = 0;
        for (int k = 62; k >= 0; k--) begin
            cand = r | (64'd1 << k);
            sq = cand * cand;
            if (sq <= v) r = cand;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [RW-1:0] sat_root(longint v);
        longint hi;
        hi = (longint'(1) << (RW - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[RW-1:0];
    endfunction

    // SV integer division truncates toward zero, like the root format.
    function automatic t_roots solve_roots(logic signed [CW-1:0] ca,
                                           logic signed [CW-1:0] cb,
                                           logic signed [CW-1:0] cc);
        longint a, b, c, nb, den, s, r1, r2;
        logic signed [127:0] disc;
        t_roots res;
        a = ca; b = cb; c = cc;
        r1 = 0; r2 = 0;
        if (a == 0) begin
            if (b == 0) begin
                res.kind = (c == 0) ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
            end else begin
                res.kind = qrs_pkg::KIND_ONE;
                r1 = (-c * (longint'(1) << FB)) / b;
            end
        end else begin
            disc = 128'(b * b) - 128'(4 * a * c);
            nb = -b * (longint'(1) << FB);
            den = 2 * a;
            if (disc < 0) begin
                res.kind = qrs_pkg::KIND_NONE;
            end else if (disc == 0) begin
                res.kind = qrs_pkg::KIND_ONE;
                r1 = nb / den;
            end else begin
                res.kind = qrs_pkg::KIND_TWO;
                s = isqrt(disc << (2 * FB));
                r1 = (nb - s) / den;
                r2 = (nb + s) / den;
            end
        end
        res.r1 = sat_root(r1);
        res.r2 = sat_root(r2);
        return res;
    endfunction

    function automatic t_roots pick(qrs_pkg::t_kind k, longint r1, longint r2);
        t_roots t;
        t.kind = k; t.r1 = r1[RW-1:0]; t.r2 = r2[RW-1:0];
        return t;
    endfunction

    task automatic send_triple(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                               logic signed [CW-1:0] c, bit typed, t_roots want);
        t_roots pred;
        int gap;
        if (!tail_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            coef_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pred = solve_roots(a, b, c);
        if (typed && pred != want) begin
            errors++;
            if (errors <= 10)
                $display("table mismatch a=%0d b=%0d c=%0d: exp %0d %0d %0d got %0d %0d %0d",
                         a, b, c, want.kind, want.r1, want.r2,
                         pred.kind, pred.r1, pred.r2);
        end
        coef_ch.valid  <= 1'b1;
        coef_ch.coef_a <= a;
        coef_ch.coef_b <= b;
        coef_ch.coef_c <= c;
        do @(posedge i_clk); while (!coef_ch.ready);
        roots_q.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // Result side: random stall bursts, compare at the rising edge.
    initial begin
        int stall;
        t_roots exp_r;
        root_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!tail_phase && stall == 0 && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 6);
            if (stall > 0) begin
                stall--;
                root_ch.ready <= 1'b0;
            end else begin
                root_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (i_rst_n && root_ch.valid && root_ch.ready) begin
                if (roots_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result item");
                end else begin
                    exp_r = roots_q.pop_front();
                    if (root_ch.solution_kind !== exp_r.kind
                            || root_ch.first_root !== exp_r.r1
                            || root_ch.second_root !== exp_r.r2) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                     exp_r.kind, exp_r.r1, exp_r.r2,
                                     root_ch.solution_kind, root_ch.first_root,
                                     root_ch.second_root);
                    end
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_roots none;
        logic signed [CW-1:0] a, b, c, r, s;
        int sel, budget;
        none = pick(qrs_pkg::KIND_NONE, 0, 0);
        coef_ch.valid = 1'b0;
        coef_ch.coef_a = '0;
        coef_ch.coef_b = '0;
        coef_ch.coef_c = '0;

        rows.push_back('{0, 0, 0, 1, pick(qrs_pkg::KIND_ALL, 0, 0)});
        rows.push_back('{0, 0, 5, 1, none});
        rows.push_back('{0, 0, -32768, 1, none});
        rows.push_back('{0, 2, -4, 1, pick(qrs_pkg::KIND_ONE, 2 * 65536, 0)});
        rows.push_back('{1, 0, 1, 1, none});
        rows.push_back('{1, -2, 1, 1, pick(qrs_pkg::KIND_ONE, 65536, 0)});
        rows.push_back('{1, 0, -1, 1, pick(qrs_pkg::KIND_TWO, -65536, 65536)});
        rows.push_back('{1, -3, 2, 1, pick(qrs_pkg::KIND_TWO, 65536, 2 * 65536)});
        rows.push_back('{0, 1, -32768, 1,
                         pick(qrs_pkg::KIND_ONE, 64'sd32768 * 65536, 0)});
        rows.push_back('{0, -1, -32768, 1,
                         pick(qrs_pkg::KIND_ONE, -64'sd32768 * 65536, 0)});
        rows.push_back('{0, -32768, 32767, 0, none});
        rows.push_back('{32767, 32767, 32767, 0, none});
        rows.push_back('{-32768, -32768, -32768, 0, none});
        rows.push_back('{1, -32768, -32768, 0, none});
        rows.push_back('{-32768, 32767, 32767, 0, none});
        rows.push_back('{1, 32767, 0, 0, none});
        rows.push_back('{-1, 1, 32767, 0, none});
        rows.push_back('{3, 1, -7, 0, none});
        rows.push_back('{-5, 2, 9, 0, none});
        rows.push_back('{4, 4, 1, 0, none});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) send_triple(rows[k].a, rows[k].b, rows[k].c, rows[k].typed,
                                      rows[k].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // hold off until every result is back
                coef_ch.valid <= 1'b0;
                while (roots_q.size() != 0) @(negedge i_clk);
            end
            if (n == N_RANDOM - 150) tail_phase = 1;
            sel = $urandom_range(0, 9);
            a = CW'($urandom); b = CW'($urandom); c = CW'($urandom);
            case (sel)
                0: a = 0;
                1: begin a = 0; b = 0; if ($urandom_range(0, 1)) c = 0; end
                2: begin
                    // integer roots r, s: a(x-r)(x-s)
                    a = CW'($urandom_range(1, 8));
                    if ($urandom_range(0, 1)) a = -a;
                    r = CW'($signed(8'($urandom)));
                    s = $urandom_range(0, 1) ? r : CW'($signed(8'($urandom)));
                    b = -a * (r + s);
                    c = a * r * s;
                end
                3: begin a = CW'($signed(5'($urandom))); b = CW'($signed(6'($urandom)));
                         c = CW'($signed(5'($urandom))); end
                default: ;
            endcase
            send_triple(a, b, c, 0, none);
        end
        coef_ch.valid <= 1'b0;

        budget = 0;
        while (roots_q.size() != 0 && budget < 100000) begin
            @(negedge i_clk);
            budget++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);
        if (errors == 0 && roots_q.size() == 0 && !root_ch.valid) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
